### sv/encp_pkg.sv
// encp_pkg: shared types and constants for the edge projection pipeline.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package encp_pkg;

	localparam int CRD_W = 32;   // input coordinate width
	localparam int SCR_W = 16;   // screen coordinate width
	localparam int FOC_W = 32;
	localparam int HLF_W = 15;
	localparam int NZ_W  = 16;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_FOCAL = 2'd0;
	localparam reg_idx_t REG_HALF_W = 2'd1;
	localparam reg_idx_t REG_HALF_H = 2'd2;
	localparam reg_idx_t REG_NEAR = 2'd3;

	localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7FFF;
	localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;

	// segment data that rides alongside the crossing divider
	typedef struct packed {
		logic fa;
		logic fb;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] az;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by_coord;
		logic signed [CRD_W-1:0] bz;
	} pass_t;

endpackage
`default_nettype wire

### sv/edge_near_clip_project.sv
// Edge projection with near-plane clipping.
//
// Usage: present a segment on ax..bz and pulse start; the transfer happens at
// an edge where start is high and busy is low. busy is high in reset and
// in the cycle after reset release; after that one segment may be started
// every cycle. Each segment yields one result, shown for exactly one cycle
// with done high: visible, sx1/sy1 (endpoint A or its clipped replacement),
// sx2/sy2. The pipeline has three front stages, a 32-stage divider for the
// z=0 crossing, three stages of point select, focal multiply and magnitude,
// a (63 - COORD_FRAC_BITS)-stage divider for the perspective divide, and
// one output stage. Throughput is one segment per clock. There is no
// back-pressure: done cannot be held off.
// Reset empties the pipeline (no done afterwards for items in flight) and
// loads focal 220.0, half size 960 x 540, near depth 66.
// Configuration: cfg_we with cfg_idx/cfg_wdata writes a register at once;
// write only while no segment is in flight.
// Depends on encp_pkg and encp_div.
`timescale 1ns / 1ps
`default_nettype none
module edge_near_clip_project #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [encp_pkg::CRD_W-1:0] ax,
	input  wire logic signed [encp_pkg::CRD_W-1:0] ay,
	input  wire logic signed [encp_pkg::CRD_W-1:0] az,
	input  wire logic signed [encp_pkg::CRD_W-1:0] bx,
	input  wire logic signed [encp_pkg::CRD_W-1:0] by_coord,
	input  wire logic signed [encp_pkg::CRD_W-1:0] bz,
	input  wire logic                          cfg_we,
	input  wire encp_pkg::reg_idx_t            cfg_idx,
	input  wire logic [encp_pkg::FOC_W-1:0]    cfg_wdata,
	output logic                               done,
	output logic                               visible,
	output logic signed [encp_pkg::SCR_W-1:0]  sx1,
	output logic signed [encp_pkg::SCR_W-1:0]  sy1,
	output logic signed [encp_pkg::SCR_W-1:0]  sx2,
	output logic signed [encp_pkg::SCR_W-1:0]  sy2
);
	import encp_pkg::*;

	localparam int F     = COORD_FRAC_BITS;
	localparam int XQW   = CRD_W;            // crossing quotient bits
	localparam int XDW   = CRD_W;
	localparam int PMW   = 2*CRD_W - 1;      // |c*focal| bits
	localparam int PDW   = CRD_W - 1 + F;    // z << F
	localparam int PQW   = PMW - F;
	localparam int PNPAD = PDW + PQW - PMW;
	localparam int SW    = PQW + 2;
	localparam int PW    = $bits(pass_t);

	// config registers
	logic [FOC_W-1:0] focal_q;
	logic [HLF_W-1:0] half_w_q, half_h_q;
	logic [NZ_W-1:0]  near_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= FOC_W'(14417920);
			half_w_q <= HLF_W'(960);
			half_h_q <= HLF_W'(540);
			near_q   <= NZ_W'(66);
			busy_q   <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_FOCAL:  focal_q  <= cfg_wdata;
					REG_HALF_W: half_w_q <= cfg_wdata[HLF_W-1:0];
					REG_HALF_H: half_h_q <= cfg_wdata[HLF_W-1:0];
					REG_NEAR:   near_q   <= cfg_wdata[NZ_W-1:0];
					default: ;
				endcase
			end
		end
	end
	assign busy = busy_q;

	// stage 1: capture
	logic  v_s1;
	pass_t p_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy_q;
	end
	always_ff @(posedge clk) begin
		p_s1 <= '{fa: az > 0, fb: bz > 0, ax: ax, ay: ay, az: az,
			bx: bx, by_coord: by_coord, bz: bz};
	end

	// stage 2: crossing cross-products; f is the front endpoint
	logic signed [CRD_W-1:0] xf, yf, zf, xb, yb, zb;
	logic signed [CRD_W:0]   dsum;
	always_comb begin
		if (p_s1.fb) begin
			xf = p_s1.bx; yf = p_s1.by_coord; zf = p_s1.bz;
			xb = p_s1.ax; yb = p_s1.ay;       zb = p_s1.az;
		end else begin
			xf = p_s1.ax; yf = p_s1.ay;       zf = p_s1.az;
			xb = p_s1.bx; yb = p_s1.by_coord; zb = p_s1.bz;
		end
		dsum = {zf[CRD_W-1], zf} - {zb[CRD_W-1], zb};
	end

	logic                      v_s2;
	pass_t                     p_s2;
	logic signed [2*CRD_W-1:0] pxb_s2, pxf_s2, pyb_s2, pyf_s2;
	logic [XDW-1:0]            den_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		p_s2   <= p_s1;
		pxb_s2 <= xb * zf;
		pxf_s2 <= xf * zb;
		pyb_s2 <= yb * zf;
		pyf_s2 <= yf * zb;
		den_s2 <= dsum[XDW-1:0];
	end

	// stage 3: numerator sign and magnitude
	logic signed [2*CRD_W:0] nx, ny, nxm, nym;
	always_comb begin
		nx  = {pxb_s2[2*CRD_W-1], pxb_s2} - {pxf_s2[2*CRD_W-1], pxf_s2};
		ny  = {pyb_s2[2*CRD_W-1], pyb_s2} - {pyf_s2[2*CRD_W-1], pyf_s2};
		nxm = nx[2*CRD_W] ? -nx : nx;
		nym = ny[2*CRD_W] ? -ny : ny;
	end

	function automatic logic [XDW-1:0] den_s3_next(input logic [XDW-1:0] d);
		// a zero divisor only shows up when no endpoint is clipped
		den_s3_next = (d == '0) ? XDW'(1) : d;
	endfunction

	logic                   v_s3;
	pass_t                  p_s3;
	logic [2*CRD_W-1:0]     nmx_s3, nmy_s3;
	logic                   sgx_s3, sgy_s3;
	logic [XDW-1:0]         den_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		p_s3   <= p_s2;
		nmx_s3 <= nxm[2*CRD_W-1:0];
		nmy_s3 <= nym[2*CRD_W-1:0];
		sgx_s3 <= nx[2*CRD_W];
		sgy_s3 <= ny[2*CRD_W];
		den_s3 <= den_s3_next(den_s2);
	end

	// crossing dividers
	logic              xv, xsg, ysg;
	logic [XQW-1:0]    xq, yq;
	logic [XDW-1:0]    xr_unused, yr_unused;
	logic [PW:0]       xtag;
	logic              yv;
	pass_t             p_x;

	encp_div #(.QW(XQW), .DW(XDW), .TW(PW+1)) u_xdiv (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .num(nmx_s3), .den(den_s3),
		.tag_in({sgx_s3, p_s3}), .out_valid(xv), .quo(xq), .rem(xr_unused),
		.tag_out(xtag)
	);
	encp_div #(.QW(XQW), .DW(XDW), .TW(1)) u_ydiv (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .num(nmy_s3), .den(den_s3),
		.tag_in(sgy_s3), .out_valid(yv), .quo(yq), .rem(yr_unused),
		.tag_out(ysg)
	);

	logic signed [CRD_W:0] xc, yc;
	logic [NZ_W-1:0]       nz;
	always_comb begin
		xsg = xtag[PW];
		p_x = pass_t'(xtag[PW-1:0]);
		xc  = xsg ? -$signed({1'b0, xq}) : $signed({1'b0, xq});
		yc  = ysg ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
		nz  = (near_q == '0) ? NZ_W'(1) : near_q;
	end

	// stage 4: choose the two projected points
	logic                    v_s4, vis_s4;
	logic signed [CRD_W-1:0] cax_s4, cay_s4, cbx_s4, cby_s4;
	logic [CRD_W-2:0]        za_s4, zb_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= xv && yv;
	end
	always_ff @(posedge clk) begin
		vis_s4 <= p_x.fa || p_x.fb;
		if (p_x.fa) begin
			cax_s4 <= p_x.ax; cay_s4 <= p_x.ay; za_s4 <= p_x.az[CRD_W-2:0];
		end else begin
			cax_s4 <= xc[CRD_W-1:0]; cay_s4 <= yc[CRD_W-1:0];
			za_s4  <= (CRD_W-1)'(nz);
		end
		if (p_x.fb) begin
			cbx_s4 <= p_x.bx; cby_s4 <= p_x.by_coord; zb_s4 <= p_x.bz[CRD_W-2:0];
		end else begin
			cbx_s4 <= xc[CRD_W-1:0]; cby_s4 <= yc[CRD_W-1:0];
			zb_s4  <= (CRD_W-1)'(nz);
		end
	end

	// stage 5: focal multiply
	logic signed [FOC_W:0]     fs;
	logic                      v_s5, vis_s5;
	logic signed [2*CRD_W-1:0] pax_s5, pay_s5, pbx_s5, pby_s5;
	logic [CRD_W-2:0]          za_s5, zb_s5;
	assign fs = $signed({1'b0, focal_q});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		vis_s5 <= vis_s4;
		pax_s5 <= cax_s4 * fs;
		pay_s5 <= cay_s4 * fs;
		pbx_s5 <= cbx_s4 * fs;
		pby_s5 <= cby_s4 * fs;
		za_s5  <= za_s4;
		zb_s5  <= zb_s4;
	end

	// stage 6: magnitudes, divisors; rows subtract, so their sign flips
	function automatic logic [PMW-1:0] mag(input logic signed [2*CRD_W-1:0] p);
		logic signed [2*CRD_W-1:0] a;
		a   = p[2*CRD_W-1] ? -p : p;
		mag = a[PMW-1:0];
	endfunction

	logic                       v_s6, vis_s6;
	logic [PMW-1:0]             m_s6 [4];
	logic [3:0]                 ng_s6;
	logic [PDW-1:0]             da_s6, db_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		vis_s6  <= vis_s5;
		m_s6[0] <= mag(pax_s5);
		m_s6[1] <= mag(pay_s5);
		m_s6[2] <= mag(pbx_s5);
		m_s6[3] <= mag(pby_s5);
		ng_s6   <= {!pby_s5[2*CRD_W-1], pbx_s5[2*CRD_W-1],
			!pay_s5[2*CRD_W-1], pax_s5[2*CRD_W-1]};
		da_s6   <= {za_s5, {F{1'b0}}};
		db_s6   <= {zb_s5, {F{1'b0}}};
	end

	// perspective dividers: sx1, sy1, sx2, sy2
	logic [3:0]     pv;
	logic [PQW-1:0] pq [4];
	logic [PDW-1:0] pr [4];
	logic [3:0]     png;
	logic [1:0]     tag0;
	logic [PDW-1:0] pden [4];
	assign pden[0] = da_s6;
	assign pden[1] = da_s6;
	assign pden[2] = db_s6;
	assign pden[3] = db_s6;

	encp_div #(.QW(PQW), .DW(PDW), .TW(2)) u_pdiv0 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6),
		.num({{PNPAD{1'b0}}, m_s6[0]}), .den(pden[0]),
		.tag_in({vis_s6, ng_s6[0]}), .out_valid(pv[0]), .quo(pq[0]), .rem(pr[0]),
		.tag_out(tag0)
	);
	assign png[0] = tag0[0];

	for (genvar k = 1; k < 4; k++) begin : g_pdiv
		encp_div #(.QW(PQW), .DW(PDW), .TW(1)) u_pdiv (
			.clk(clk), .arst_n(arst_n), .in_valid(v_s6),
			.num({{PNPAD{1'b0}}, m_s6[k]}), .den(pden[k]),
			.tag_in(ng_s6[k]), .out_valid(pv[k]), .quo(pq[k]), .rem(pr[k]),
			.tag_out(png[k])
		);
	end

	// final: truncate toward zero, then clamp
	logic signed [SCR_W-1:0] scr [4];
	for (genvar k = 0; k < 4; k++) begin : g_fin
		logic signed [SW-1:0] hs, qs, dif, sv;
		always_comb begin
			hs  = $signed(SW'((k % 2 == 0) ? half_w_q : half_h_q));
			qs  = $signed(SW'(pq[k]));
			dif = hs - qs;
			if (!png[k])
				sv = hs + qs;
			else if ((pr[k] != '0) && (dif > 0))
				sv = dif - SW'(1);
			else
				sv = dif;
			if (sv > SW'(SCR_MAX))
				scr[k] = SCR_MAX;
			else if (sv < $signed(SW'(SCR_MIN)))
				scr[k] = SCR_MIN;
			else
				scr[k] = sv[SCR_W-1:0];
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= &pv;
	end
	always_ff @(posedge clk) begin
		visible <= tag0[1];
		sx1 <= tag0[1] ? scr[0] : '0;
		sy1 <= tag0[1] ? scr[1] : '0;
		sx2 <= tag0[1] ? scr[2] : '0;
		sy2 <= tag0[1] ? scr[3] : '0;
	end
	assign done = done_q;

endmodule
`default_nettype wire

### sv/encp_div.sv
// encp_div: pipelined restoring unsigned divider, one quotient bit per stage.
// Requires num >> QW < den. Carries a sideband tag. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module encp_div #(
	parameter int QW = 32,
	parameter int DW = 32,
	parameter int TW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [DW+QW-1:0]  num,
	input  wire logic [DW-1:0]     den,
	input  wire logic [TW-1:0]     tag_in,
	output logic                   out_valid,
	output logic [QW-1:0]          quo,
	output logic [DW-1:0]          rem,
	output logic [TW-1:0]          tag_out
);

	logic [QW:0]    vld_s;
	logic [DW-1:0]  rem_s [QW+1];
	logic [QW-1:0]  nq_s  [QW+1];
	logic [DW-1:0]  den_s [QW+1];
	logic [TW-1:0]  tag_s [QW+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = num[DW+QW-1:QW];
	assign nq_s[0]  = num[QW-1:0];
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;
		always_comb begin
			trial = {rem_s[i], nq_s[i][QW-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = trial >= {1'b0, den_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_s[i+1]  <= {nq_s[i][QW-2:0], ge};
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = nq_s[QW];
	assign rem       = rem_s[QW];
	assign tag_out   = tag_s[QW];

endmodule
`default_nettype wire

### sv/encp_chk.sv
// encp_chk: port-level checks on edge_near_clip_project, bound to the top.
// Depends on encp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module encp_chk #(
	parameter int COORD_FRAC_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic signed [encp_pkg::CRD_W-1:0] az,
	input wire logic signed [encp_pkg::CRD_W-1:0] bz,
	input wire logic                          done,
	input wire logic                          visible,
	input wire logic signed [encp_pkg::SCR_W-1:0] sx1,
	input wire logic signed [encp_pkg::SCR_W-1:0] sy1,
	input wire logic signed [encp_pkg::SCR_W-1:0] sx2,
	input wire logic signed [encp_pkg::SCR_W-1:0] sy2
);
	import encp_pkg::*;

	localparam int LAT = 102 - COORD_FRAC_BITS;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without transfer");

	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> visible == $past(az > 0 || bz > 0, LAT))
		else $error("visible flag mismatch");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> sx1 == '0 && sy1 == '0 && sx2 == '0 && sy2 == '0)
		else $error("hidden segment with nonzero coordinates");

endmodule

bind edge_near_clip_project encp_chk #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_encp_chk (.*);
`default_nettype wire

### dv/tb.sv
// tb: self-checking testbench for edge_near_clip_project (segment projection
// with near-plane clipping). Depends on encp_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
	import encp_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 102 - FRAC;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [CRD_W-1:0] ax, ay, az, bx, by_coord, bz;
	} seg_t;

	typedef struct {
		logic vis;
		logic signed [SCR_W-1:0] sx1, sy1, sx2, sy2;
	} scr_t;

	typedef struct {
		seg_t seg;
		bit   has_exp;
		scr_t exp_scr;
	} row_t;

	logic clk, arst_n, start, busy, cfg_we, done, visible;
	logic signed [CRD_W-1:0] ax, ay, az, bx, by_coord, bz;
	reg_idx_t cfg_idx;
	logic [FOC_W-1:0] cfg_wdata;
	logic signed [SCR_W-1:0] sx1, sy1, sx2, sy2;

	edge_near_clip_project dut (.*);

	// shadow of the block's registers
	longint focal = 14417920, half_w = 960, half_h = 540, near_z = 66;

	scr_t   screen_q[$];
	int     errors = 0;
	longint cycles = 0;
	int     idle_pct = 0;
	row_t   dir_rows[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [SCR_W-1:0] sat(longint v);
		if (v > 32767)
			return SCR_MAX;
		if (v < -32768)
			return SCR_MIN;
		return v[SCR_W-1:0];
	endfunction

	// exact half +/- c*f/(z*2^F), truncated toward zero
	function automatic longint axis_pos(longint c, longint z, longint half, bit sub);
		longint p, d, q, r, s;
		p = c * focal;
		d = z <<< FRAC;
		q = p / d;
		r = p - q * d;
		if (r < 0) begin
			q -= 1;
			r += d;
		end
		if (!sub) begin
			s = half + q;
			if (r != 0 && s < 0)
				s += 1;
		end else begin
			s = half - q;
			if (r != 0 && s > 0)
				s -= 1;
		end
		return s;
	endfunction

	function automatic longint crossing(longint cb, longint zb, longint cf, longint zf);
		return (cb * zf - cf * zb) / (zf - zb);
	endfunction

	function automatic scr_t project_seg(seg_t s);
		scr_t o;
		longint xa, ya, za, xb, yb, zb, nz, x1, y1, z1, x2, y2, z2;
		xa = s.ax; ya = s.ay; za = s.az;
		xb = s.bx; yb = s.by_coord; zb = s.bz;
		nz = (near_z == 0) ? 1 : near_z;
		o = '{default: 0};
		if (za <= 0 && zb <= 0)
			return o;
		o.vis = 1;
		x1 = xa; y1 = ya; z1 = za;
		x2 = xb; y2 = yb; z2 = zb;
		if (za <= 0) begin
			x1 = crossing(xa, za, xb, zb);
			y1 = crossing(ya, za, yb, zb);
			z1 = nz;
		end else if (zb <= 0) begin
			x2 = crossing(xb, zb, xa, za);
			y2 = crossing(yb, zb, ya, za);
			z2 = nz;
		end
		o.sx1 = sat(axis_pos(x1, z1, half_w, 0));
		o.sy1 = sat(axis_pos(y1, z1, half_h, 1));
		o.sx2 = sat(axis_pos(x2, z2, half_w, 0));
		o.sy2 = sat(axis_pos(y2, z2, half_h, 1));
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** edge_near_clip_project: FAILED **");
			$finish;
		end
		if (arst_n && done) begin
			if (screen_q.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				scr_t e;
				e = screen_q.pop_front();
				if (visible !== e.vis || sx1 !== e.sx1 || sy1 !== e.sy1 ||
				    sx2 !== e.sx2 || sy2 !== e.sy2) begin
					$display("%0t: expected vis=%0d %0d,%0d %0d,%0d got vis=%0d %0d,%0d %0d,%0d",
					         $time, e.vis, e.sx1, e.sy1, e.sx2, e.sy2,
					         visible, sx1, sy1, sx2, sy2);
					errors++;
				end
			end
		end
	end

	// write enable drops for one cycle after each write
	task automatic write_reg(reg_idx_t idx, logic [FOC_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_FOCAL:  focal = val;
			REG_HALF_W: half_w = val[HLF_W-1:0];
			REG_HALF_H: half_h = val[HLF_W-1:0];
			REG_NEAR:   near_z = val[NZ_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (screen_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one transfer, preceded by a random gap at the current idle rate;
	// start stays high after the transfer until the next gap or drain
	task automatic send_seg(seg_t s, bit has_exp = 0, scr_t fixed = '{default: 0});
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		ax <= s.ax; ay <= s.ay; az <= s.az;
		bx <= s.bx; by_coord <= s.by_coord; bz <= s.bz;
		do
			@(posedge clk);
		while (busy);
		screen_q.insert(screen_q.size(), has_exp ? fixed : project_seg(s));
	endtask

	function automatic logic signed [CRD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(20 << FRAC)) - (10 << FRAC);
			2: return $signed($urandom_range(4000)) - 2000;
			default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	function automatic seg_t rand_seg();
		seg_t s;
		s.ax = rand_coord(); s.ay = rand_coord();
		s.bx = rand_coord(); s.by_coord = rand_coord();
		s.az = rand_coord(); s.bz = rand_coord();
		if ($urandom_range(3) != 0)
			s.az = $urandom_range(1, 50 << FRAC);
		if ($urandom_range(3) == 0)
			s.bz = -$signed($urandom_range(50 << FRAC));
		else if ($urandom_range(2) != 0)
			s.bz = $urandom_range(1, 50 << FRAC);
		return s;
	endfunction

	initial begin
		seg_t s;
		scr_t z;
		start = 0; cfg_we = 0; cfg_idx = REG_FOCAL; cfg_wdata = 0;
		ax = 0; ay = 0; az = 0; bx = 0; by_coord = 0; bz = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		z = '{default: 0};
		// directed rows; typed-in results where obvious
		dir_rows = '{
			'{'{0, 0, 32'sh10000, 0, 0, 32'sh10000}, 1, '{1, 960, 540, 960, 540}},
			'{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0}},
			'{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, -1, 5, 5, 32'sh80000000}, 1,
			  '{0, 0, 0, 0, 0}},
			'{'{32'sh7FFFFFFF, 32'sh80000000, 1, 32'sh80000000, 32'sh7FFFFFFF, 1}, 1,
			  '{1, SCR_MAX, SCR_MAX, SCR_MIN, SCR_MIN}},
			'{'{32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, -32'sh20000,
			    32'sh7FFFFFFF}, 0, z},
			'{'{32'sh10000, 32'sh10000, -32'sh10000, 32'sh20000, 32'sh30000,
			    32'sh10000}, 0, z},
			'{'{32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh30000, 0}, 0, z},
			'{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			    32'sh80000000, 32'sh7FFFFFFF}, 0, z},
			'{'{-32'sh1, 32'sh1, 32'sh7FFFFFFF, 32'sh1, -32'sh1, 32'sh7FFFFFFF}, 0, z},
			'{'{-32'sh12345, 32'sh54321, 32'sh8000, 32'sh777, -32'sh999, -32'sh8000},
			  0, z}
		};
		foreach (dir_rows[i])
			send_seg(dir_rows[i].seg, dir_rows[i].has_exp, dir_rows[i].exp_scr);
		drain();

		// register extremes, then random values and the reset defaults, each followed by three random segments
		for (int p = 0; p < 4; p++) begin
			repeat (LATENCY) @(posedge clk);
			case (p)
				0: begin
					write_reg(REG_FOCAL, 32'hFFFF_FFFF); write_reg(REG_HALF_W, 0);
					write_reg(REG_HALF_H, 15'h7FFF); write_reg(REG_NEAR, 0);
				end
				1: begin
					write_reg(REG_FOCAL, 0); write_reg(REG_HALF_W, 15'h7FFF);
					write_reg(REG_HALF_H, 0); write_reg(REG_NEAR, 16'hFFFF);
				end
				2: begin
					write_reg(REG_FOCAL, $urandom); write_reg(REG_HALF_W, $urandom);
					write_reg(REG_HALF_H, $urandom); write_reg(REG_NEAR, 1);
				end
				default: begin
					write_reg(REG_FOCAL, 14417920); write_reg(REG_HALF_W, 960);
					write_reg(REG_HALF_H, 540); write_reg(REG_NEAR, 66);
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				s = rand_seg();
				send_seg(s);
			end
			drain();
		end

		// random phases; idle percentages 0, 47, 38
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 47 : 38;
			for (int k = 0; k < 230; k++) begin
				s = rand_seg();
				send_seg(s);
				if (k == 100) drain();
			end
			drain();
			repeat (LATENCY) @(posedge clk);
			if (ph % 2 == 0) begin
				write_reg(REG_FOCAL, $urandom_range(1 << 26));
				write_reg(REG_NEAR, $urandom_range(1, 65535));
			end else begin
				write_reg(REG_HALF_W, $urandom_range(32767));
				write_reg(REG_HALF_H, $urandom_range(32767));
			end
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("** edge_near_clip_project: PASSED **");
		else
			$display("** edge_near_clip_project: FAILED **");
		$finish;
	end
endmodule
